/* sv/ffa_pkg.sv */
// shared types and constants for the first-fit heap allocator
// no dependencies
package ffa_pkg;

    localparam int unsigned ADDR_W        = 16;
    localparam int unsigned STORE_DEPTH   = 65536;
    localparam int unsigned DEF_MEM_SIZE  = 65536;
    localparam int unsigned DEF_HDR_BYTES = 9;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    typedef struct packed {
        logic        func;
        logic [16:0] request_size;
        logic [15:0] release_address;
    } ffa_req_t;

    typedef struct packed {
        logic [15:0] payload_address;
        logic [1:0]  status;
        logic [15:0] free_bytes;
    } ffa_rsp_t;

    typedef struct packed {
        logic        free;
        logic [15:0] size;
        logic [15:0] next;
    } ffa_hdr_t;

    localparam int unsigned HDR_W = $bits(ffa_hdr_t);

endpackage

/* sv/first_fit_heap_allocator_unit.sv */
// first-fit heap allocator with block split and free-neighbor merge
// depends on ffa_pkg and ffa_ram
//
// usage:
//   s_req carries one request (allocate or release) under s_valid/s_ready.
//   m_rsp returns one result per request under m_valid/m_ready: payload
//   address, status and the free payload byte count after the request.
// sequence:
//   headers live in one ram with registered read. allocate walks the
//   chain from address 0 to the first free block that fits and, when
//   the block is split, writes the new header in a further state. release
//   walks to the target header, marks it free and then makes a merge
//   pass over the chain from address 0; a release that finds no header,
//   or one below the header size, answers invalid without the merge pass.
//   one request is in flight at a time; the next is taken once the
//   result register is empty.
// reset:
//   aresetn (synchronous, active low) enters an init state that writes the
//   single free block header at address 0; s_ready is low in that state.
// stall:
//   the result waits in its register while m_ready is low and no new
//   request is taken until it leaves.
module first_fit_heap_allocator_unit #(
    parameter int unsigned MEM_SIZE     = ffa_pkg::DEF_MEM_SIZE,
    parameter int unsigned HEADER_BYTES = ffa_pkg::DEF_HDR_BYTES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ffa_pkg::ffa_req_t s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output ffa_pkg::ffa_rsp_t m_rsp
);

    localparam logic [15:0] HB       = 16'(HEADER_BYTES);
    localparam logic [15:0] INIT_SIZE = 16'(MEM_SIZE - HEADER_BYTES);

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_WALK_A, ST_SPLIT_W, ST_WALK_R,
        ST_M_ISSUE, ST_M_LOAD, ST_M_STEP, ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    ffa_pkg::ffa_rsp_t m_rsp_reg, m_rsp_next;
    logic [15:0]       free_total_reg, free_total_next;
    ffa_pkg::ffa_req_t req_reg, req_next;
    logic [15:0]       rd_addr_reg, rd_addr_next;
    logic [15:0]       a_reg, a_next;
    ffa_pkg::ffa_hdr_t b_reg, b_next;
    logic [15:0]       addr_out_reg, addr_out_next;
    logic [1:0]        status_reg, status_next;

    logic                          wr_en;
    logic [ffa_pkg::ADDR_W-1:0]    wr_addr;
    ffa_pkg::ffa_hdr_t             wr_hdr;
    logic [ffa_pkg::HDR_W-1:0]     rd_data;
    ffa_pkg::ffa_hdr_t             rd_hdr;

    logic        fits;
    logic        do_split;
    logic [15:0] target;
    logic [15:0] req16;
    logic [15:0] merged_size;

    assign rd_hdr      = ffa_pkg::ffa_hdr_t'(rd_data);
    assign req16       = req_reg.request_size[15:0];
    assign fits        = rd_hdr.free && ({1'b0, rd_hdr.size} >= req_reg.request_size);
    assign do_split    = {2'b0, rd_hdr.size} > ({1'b0, req_reg.request_size} + {2'b0, HB});
    assign target      = req_reg.release_address - HB;
    assign merged_size = b_reg.size + rd_hdr.size + HB;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    ffa_ram #(
        .WIDTH(ffa_pkg::HDR_W),
        .DEPTH(ffa_pkg::STORE_DEPTH)
    ) u_hdr_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_hdr),
        .rd_addr(rd_addr_next),
        .rd_data(rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        m_rsp_next      = m_rsp_reg;
        free_total_next = free_total_reg;
        req_next        = req_reg;
        rd_addr_next    = rd_addr_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        addr_out_next   = addr_out_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_addr_reg;
        wr_hdr          = rd_hdr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_hdr     = '{free: 1'b1, size: INIT_SIZE, next: 16'd0};
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next      = s_req;
                    addr_out_next = '0;
                    status_next   = ffa_pkg::STAT_OK;
                    rd_addr_next  = '0;
                    if (s_req.func == ffa_pkg::FUNC_ALLOC) begin
                        state_next = ST_WALK_A;
                    end else if (s_req.release_address < HB) begin
                        status_next = ffa_pkg::STAT_INVALID;
                        state_next  = ST_RESP;
                    end else begin
                        state_next = ST_WALK_R;
                    end
                end
            end
            ST_WALK_A: begin
                if (fits) begin
                    addr_out_next = rd_addr_reg + HB;
                    b_next        = rd_hdr;
                    b_next.free   = 1'b0;
                    if (do_split) begin
                        // rest of the block stays free behind a new header
                        wr_en           = 1'b1;
                        wr_addr         = rd_addr_reg + HB + req16;
                        wr_hdr          = '{free: 1'b1,
                                            size: rd_hdr.size - req16 - HB,
                                            next: rd_hdr.next};
                        b_next.size     = req16;
                        b_next.next     = wr_addr;
                        free_total_next = free_total_reg - req16 - HB;
                        state_next      = ST_SPLIT_W;
                    end else begin
                        wr_en           = 1'b1;
                        wr_hdr          = rd_hdr;
                        wr_hdr.free     = 1'b0;
                        free_total_next = free_total_reg - rd_hdr.size;
                        state_next      = ST_RESP;
                    end
                end else if (rd_hdr.next != 16'd0) begin
                    rd_addr_next = rd_hdr.next;
                end else begin
                    status_next = ffa_pkg::STAT_NOFIT;
                    state_next  = ST_RESP;
                end
            end
            ST_SPLIT_W: begin
                wr_en      = 1'b1;
                wr_hdr     = b_reg;
                state_next = ST_RESP;
            end
            ST_WALK_R: begin
                if (rd_addr_reg == target) begin
                    if (!rd_hdr.free) begin
                        free_total_next = free_total_reg + rd_hdr.size;
                    end
                    wr_en       = 1'b1;
                    wr_hdr      = rd_hdr;
                    wr_hdr.free = 1'b1;
                    state_next  = ST_M_ISSUE;
                end else if (rd_hdr.next != 16'd0) begin
                    rd_addr_next = rd_hdr.next;
                end else begin
                    status_next = ffa_pkg::STAT_INVALID;
                    state_next  = ST_RESP;
                end
            end
            ST_M_ISSUE: begin
                // read issued after the release write so entry 0 is current
                rd_addr_next = '0;
                state_next   = ST_M_LOAD;
            end
            ST_M_LOAD: begin
                a_next = '0;
                b_next = rd_hdr;
                if (rd_hdr.next == 16'd0) begin
                    state_next = ST_RESP;
                end else begin
                    rd_addr_next = rd_hdr.next;
                    state_next   = ST_M_STEP;
                end
            end
            ST_M_STEP: begin
                if (b_reg.free && rd_hdr.free) begin
                    b_next.size     = merged_size;
                    b_next.next     = rd_hdr.next;
                    wr_en           = 1'b1;
                    wr_addr         = a_reg;
                    wr_hdr          = '{free: 1'b1, size: merged_size, next: rd_hdr.next};
                    free_total_next = free_total_reg + HB;
                end else begin
                    a_next = b_reg.next;
                    b_next = rd_hdr;
                end
                if (rd_hdr.next == 16'd0) begin
                    state_next = ST_RESP;
                end else begin
                    rd_addr_next = rd_hdr.next;
                end
            end
            ST_RESP: begin
                m_valid_next = 1'b1;
                m_rsp_next   = '{payload_address: addr_out_reg,
                                 status:          status_reg,
                                 free_bytes:      free_total_reg};
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg    <= m_rsp_next;
        req_reg      <= req_next;
        rd_addr_reg  <= rd_addr_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        addr_out_reg <= addr_out_next;
        status_reg   <= status_next;
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            m_valid_reg    <= 1'b0;
            free_total_reg <= INIT_SIZE;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            free_total_reg <= free_total_next;
        end
    end

endmodule

/* sv/ffa_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ffa_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/ffa_checker.sv */
// port-level checks for the first-fit heap allocator, bound to the top level
// depends on ffa_pkg and first_fit_heap_allocator_unit
module ffa_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ffa_pkg::ffa_req_t s_req,
    input logic              m_valid,
    input logic              m_ready,
    input ffa_pkg::ffa_rsp_t m_rsp
);

    // a new request is never taken while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("request accepted while result pending");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status == ffa_pkg::STAT_OK ||
                     m_rsp.status == ffa_pkg::STAT_NOFIT ||
                     m_rsp.status == ffa_pkg::STAT_INVALID))
        else $error("bad status code");

    a_fail_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status != ffa_pkg::STAT_OK) |-> m_rsp.payload_address == 16'd0)
        else $error("failed request returned an address");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rsp)))
        else $error("result changed while stalled");

endmodule

bind first_fit_heap_allocator_unit ffa_checker u_ffa_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_req  (s_req),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_rsp  (m_rsp)
);

/* sim/tb_first_fit_heap_allocator_unit.sv */
// self-checking testbench for first_fit_heap_allocator_unit
// depends on ffa_pkg and the allocator rtl; predicts every result from its own header chain
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_unit;

    localparam int unsigned MEM_BYTES  = 65536;
    localparam int unsigned HDR_BYTES  = 9;
    localparam int unsigned IDLE_LIMIT = 40000;
    localparam int unsigned NUM_RANDOM = 1080;

    typedef struct {
        bit          is_free;
        int unsigned size;
        int unsigned next;
    } blk_hdr_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ffa_pkg::ffa_req_t s_req;
    logic              m_valid;
    logic              m_ready;
    ffa_pkg::ffa_rsp_t m_rsp;

    blk_hdr_t          heap_hdrs[int unsigned];
    int unsigned       free_total;
    ffa_pkg::ffa_rsp_t expected_rsps[$];
    ffa_pkg::ffa_req_t pending_reqs[$];
    int unsigned       live_addrs[$];
    int unsigned       freed_addrs[$];
    int unsigned       issued_cnt;
    int unsigned       accepted_cnt;
    int unsigned       error_cnt;
    int unsigned       idle_cycles;
    int unsigned       send_gap;
    int unsigned       stall_len;
    bit                req_taken;

    first_fit_heap_allocator_unit #(
        .MEM_SIZE(MEM_BYTES),
        .HEADER_BYTES(HDR_BYTES)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req(s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp(m_rsp)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void heap_reset();
        heap_hdrs.delete();
        heap_hdrs[0] = '{1'b1, MEM_BYTES - HDR_BYTES, 0};
        free_total = MEM_BYTES - HDR_BYTES;
    endfunction

    function automatic void merge_free_neighbors();
        int unsigned a;
        int unsigned guard;
        blk_hdr_t    b;
        blk_hdr_t    nx;
        a = 0;
        guard = 0;
        b = heap_hdrs[0];
        while (b.next != 0 && guard < ffa_pkg::STORE_DEPTH) begin
            nx = heap_hdrs[b.next];
            guard++;
            if (b.is_free && nx.is_free) begin
                b.size += nx.size + HDR_BYTES;
                b.next = nx.next;
                heap_hdrs[a] = b;
                free_total += HDR_BYTES;
            end else begin
                a = b.next & 16'hffff;
                b = heap_hdrs[a];
            end
        end
    endfunction

    // applies one request to the shadow heap and queues the result it gives
    function automatic void predict_heap_op(ffa_pkg::ffa_req_t req);
        int unsigned       a1;
        int unsigned       a2;
        int unsigned       guard;
        int unsigned       need;
        int unsigned       target;
        blk_hdr_t          b;
        ffa_pkg::ffa_rsp_t rsp;
        rsp = '0;
        a1 = 0;
        guard = 0;
        b = heap_hdrs[0];
        if (req.func == ffa_pkg::FUNC_ALLOC) begin
            need = 32'(req.request_size);
            while ((!b.is_free || b.size < need) && b.next != 0
                   && guard < ffa_pkg::STORE_DEPTH) begin
                a1 = b.next & 16'hffff;
                b = heap_hdrs[a1];
                guard++;
            end
            if (!b.is_free || b.size < need) begin
                rsp.status = ffa_pkg::STAT_NOFIT;
            end else begin
                if (b.size > need + HDR_BYTES) begin
                    a2 = (a1 + HDR_BYTES + need) & 16'hffff;
                    heap_hdrs[a2] = '{1'b1, b.size - need - HDR_BYTES, b.next};
                    b.size = need;
                    b.next = a2;
                    free_total -= need + HDR_BYTES;
                end else begin
                    free_total -= b.size;
                end
                b.is_free = 1'b0;
                heap_hdrs[a1] = b;
                rsp.payload_address = 16'(a1 + HDR_BYTES);
                rsp.status = ffa_pkg::STAT_OK;
                live_addrs.push_back(32'(rsp.payload_address));
            end
        end else if (req.release_address < HDR_BYTES) begin
            rsp.status = ffa_pkg::STAT_INVALID;
        end else begin
            target = req.release_address - HDR_BYTES;
            while (a1 != target && b.next != 0 && guard < ffa_pkg::STORE_DEPTH) begin
                a1 = b.next & 16'hffff;
                b = heap_hdrs[a1];
                guard++;
            end
            if (a1 != target) begin
                rsp.status = ffa_pkg::STAT_INVALID;
            end else begin
                if (!b.is_free) free_total += b.size;
                b.is_free = 1'b1;
                heap_hdrs[a1] = b;
                merge_free_neighbors();
                rsp.status = ffa_pkg::STAT_OK;
                foreach (live_addrs[i]) begin
                    if (live_addrs[i] == req.release_address) begin
                        live_addrs.delete(i);
                        break;
                    end
                end
                freed_addrs.push_back(32'(req.release_address));
                if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
            end
        end
        rsp.free_bytes = 16'(free_total);
        expected_rsps.push_back(rsp);
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 64);
        if (r < 85) return $urandom_range(65, 1024);
        if (r < 97) return $urandom_range(1025, 8192);
        return $urandom_range(8193, 65536);
    endfunction

    task automatic send_request(logic func, int unsigned size, int unsigned addr);
        ffa_pkg::ffa_req_t req;
        req.func = func;
        req.request_size = size[16:0];
        req.release_address = addr[15:0];
        pending_reqs.push_back(req);
        issued_cnt++;
        // later requests depend on the heap state this one leaves
        wait (accepted_cnt == issued_cnt);
    endtask

    // acceptance, prediction, result check and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cycles++;
            if (s_valid && s_ready) begin
                predict_heap_op(s_req);
                req_taken = 1'b1;
                accepted_cnt++;
                idle_cycles = 0;
            end
            if (m_valid && m_ready) begin
                idle_cycles = 0;
                if (expected_rsps.size() == 0) begin
                    $error("result with no request outstanding: %p", m_rsp);
                    error_cnt++;
                end else begin
                    ffa_pkg::ffa_rsp_t exp_rsp;
                    exp_rsp = expected_rsps.pop_front();
                    if (m_rsp.payload_address !== exp_rsp.payload_address) begin
                        $error("payload_address expected %0d got %0d",
                               exp_rsp.payload_address, m_rsp.payload_address);
                        error_cnt++;
                    end
                    if (m_rsp.status !== exp_rsp.status) begin
                        $error("status expected %0d got %0d", exp_rsp.status, m_rsp.status);
                        error_cnt++;
                    end
                    if (m_rsp.free_bytes !== exp_rsp.free_bytes) begin
                        $error("free_bytes expected %0d got %0d",
                               exp_rsp.free_bytes, m_rsp.free_bytes);
                        error_cnt++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // request driver and result-side stalls
    always @(negedge aclk) begin
        logic nxt_valid;
        nxt_valid = s_valid;
        if (req_taken) begin
            nxt_valid = 1'b0;
            req_taken = 1'b0;
        end
        if (aresetn && !nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() != 0) begin
                s_req <= pending_reqs.pop_front();
                nxt_valid = 1'b1;
                send_gap = pick_gap();
            end
        end
        s_valid <= nxt_valid;
        if (aresetn) begin
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                stall_len--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) stall_len = pick_gap();
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned addr;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_req = '0;
        issued_cnt = 0;
        accepted_cnt = 0;
        error_cnt = 0;
        idle_cycles = 0;
        send_gap = 0;
        stall_len = 0;
        req_taken = 1'b0;
        heap_reset();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed: size extremes, invalid releases, double release, full heap
        send_request(ffa_pkg::FUNC_ALLOC, 0, 0);
        send_request(ffa_pkg::FUNC_ALLOC, 65536, 0);
        send_request(ffa_pkg::FUNC_RELEASE, 0, 0);
        send_request(ffa_pkg::FUNC_RELEASE, 0, HDR_BYTES - 1);
        send_request(ffa_pkg::FUNC_RELEASE, 0, 65535);
        send_request(ffa_pkg::FUNC_RELEASE, 0, 12345);
        send_request(ffa_pkg::FUNC_ALLOC, 100, 0);
        send_request(ffa_pkg::FUNC_ALLOC, 200, 0);
        send_request(ffa_pkg::FUNC_RELEASE, 0, HDR_BYTES);
        send_request(ffa_pkg::FUNC_RELEASE, 0, HDR_BYTES);
        send_request(ffa_pkg::FUNC_ALLOC, 0, 0);
        send_request(ffa_pkg::FUNC_ALLOC, 100 - HDR_BYTES - 1, 0);
        send_request(ffa_pkg::FUNC_ALLOC, 65000, 0);
        while (live_addrs.size() != 0) send_request(ffa_pkg::FUNC_RELEASE, 0, live_addrs[0]);
        send_request(ffa_pkg::FUNC_ALLOC, MEM_BYTES - HDR_BYTES, 0);
        send_request(ffa_pkg::FUNC_ALLOC, 0, 0);
        send_request(ffa_pkg::FUNC_RELEASE, 0, HDR_BYTES);
        send_request(ffa_pkg::FUNC_ALLOC, MEM_BYTES - HDR_BYTES + 1, 0);

        // random: allocations mixed with releases of live blocks and some noise
        repeat (NUM_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 52) begin
                send_request(ffa_pkg::FUNC_ALLOC, pick_size(), $urandom_range(0, 65535));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75 && live_addrs.size() != 0)
                    addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                else if (r < 85 && freed_addrs.size() != 0)
                    addr = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
                else if (r < 93)
                    addr = $urandom_range(0, 65535);
                else
                    addr = $urandom_range(0, HDR_BYTES - 1);
                send_request(ffa_pkg::FUNC_RELEASE, pick_size(), addr);
            end
        end

        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
